// ===== hdl/alc_pkg.sv =====
// Shared constants, codes and types for the alarm clock controller.
package alc_pkg;

    // Length of one day in seconds; the clock wraps to zero at this count.
    localparam int DAY_SECONDS = 86400;

    // Longest entry line, in characters.
    localparam int LINE_CHARS = 8;

    // Width of the binary seconds counters.
    localparam int SEC_W = 17;

    // Event codes on the operation field.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SETCLK = 3'd1;
    localparam logic [2:0] OP_SETALM = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_DIGITS = 3'd4;

    // Mode codes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_CLOCK = 3'd1;
    localparam logic [2:0] MODE_ALARM = 3'd2;
    localparam logic [2:0] MODE_RUN   = 3'd3;
    localparam logic [2:0] MODE_RING  = 3'd4;

    // Message codes.
    localparam logic [1:0] MSG_NONE  = 2'd0;
    localparam logic [1:0] MSG_CLOCK = 2'd1;
    localparam logic [1:0] MSG_ALARM = 2'd2;
    localparam logic [1:0] MSG_BAD   = 2'd3;

    // Checked digit entry, in binary seconds and in display digits.
    typedef struct packed {
        logic             ok;
        logic [SEC_W-1:0] seconds;
        logic [3:0]       sec_ones;
        logic [2:0]       sec_tens;
        logic [3:0]       min_ones;
        logic [2:0]       min_tens;
        logic [4:0]       hours;
    } t_entry;

    // One result word as it leaves the update logic.
    typedef struct packed {
        logic [2:0] mode_now;
        logic [1:0] message;
        logic [3:0] sec_ones;
        logic [2:0] sec_tens;
        logic [3:0] min_ones;
        logic [2:0] min_tens;
        logic [3:0] hour_leds;
        logic [7:0] alarm_leds;
    } t_result;

endpackage

// ===== hdl/alarm_clock_controller_unit.sv =====
// Alarm clock controller: input register, event update and result register.
// The update logic sits between the input register and the result register,
// and the result register drives the result ports.
// Throughput: one word per cycle; input is stalled only while both registers
// hold a word and the result is stalled. Reset (synchronous, active low)
// empties both registers and clears mode, clock, alarm, display and LEDs.
module alarm_clock_controller_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic [3:0] i_digit_count,
    input  logic [3:0] i_digit_0,
    input  logic [3:0] i_digit_1,
    input  logic [3:0] i_digit_2,
    input  logic [3:0] i_digit_3,
    input  logic [3:0] i_digit_4,
    input  logic [3:0] i_digit_5,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_mode_now,
    output logic [1:0] o_message,
    output logic [3:0] o_sec_ones,
    output logic [2:0] o_sec_tens,
    output logic [3:0] o_min_ones,
    output logic [2:0] o_min_tens,
    output logic [3:0] o_hour_leds,
    output logic [7:0] o_alarm_leds
);

    logic                r_in_vld;
    logic [2:0]          r_op;
    logic [3:0]          r_cnt;
    logic [3:0]          r_d0, r_d1, r_d2, r_d3, r_d4, r_d5;
    logic                r_out_vld;
    alc_pkg::t_result    r_out;
    alc_pkg::t_result    result;
    alc_pkg::t_entry     entry;
    logic                advance;
    logic                accept;

    // Pipeline flow: a held word moves on when the result register is free.
    always_comb begin
        advance    = r_in_vld && (!r_out_vld || !i_out_stall);
        o_in_stall = r_in_vld && !advance;
        accept     = i_in_valid && !o_in_stall;
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept || (r_in_vld && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_cnt <= i_digit_count;
            r_d0  <= i_digit_0;
            r_d1  <= i_digit_1;
            r_d2  <= i_digit_2;
            r_d3  <= i_digit_3;
            r_d4  <= i_digit_4;
            r_d5  <= i_digit_5;
        end
    end

    // Entry check and conversion.
    alc_entry u_entry (
        .i_digit_count (r_cnt),
        .i_digit_0     (r_d0),
        .i_digit_1     (r_d1),
        .i_digit_2     (r_d2),
        .i_digit_3     (r_d3),
        .i_digit_4     (r_d4),
        .i_digit_5     (r_d5),
        .o_entry       (entry)
    );

    // Mode and time state.
    alc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (advance),
        .i_operation   (r_op),
        .i_digit_count (r_cnt),
        .i_entry       (entry),
        .o_result      (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= advance || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_mode_now   = r_out.mode_now;
    assign o_message    = r_out.message;
    assign o_sec_ones   = r_out.sec_ones;
    assign o_sec_tens   = r_out.sec_tens;
    assign o_min_ones   = r_out.min_ones;
    assign o_min_tens   = r_out.min_tens;
    assign o_hour_leds  = r_out.hour_leds;
    assign o_alarm_leds = r_out.alarm_leds;

endmodule

// ===== hdl/alc_entry.sv =====
// Digit entry checker and converter to seconds and display digits.
module alc_entry (
    input  logic [3:0]      i_digit_count,
    input  logic [3:0]      i_digit_0,
    input  logic [3:0]      i_digit_1,
    input  logic [3:0]      i_digit_2,
    input  logic [3:0]      i_digit_3,
    input  logic [3:0]      i_digit_4,
    input  logic [3:0]      i_digit_5,
    output alc_pkg::t_entry o_entry
);

    logic [3:0] e0, e1, e2, e3, e4, e5;
    logic       over9;
    logic       bad;

    // Digits beyond the count take no part. A count is not clamped to the line
    // length, but every threshold used here lies below the line length, so a
    // longer count takes all six digits and changes nothing else.
    always_comb begin
        e0 = (i_digit_count > 4'd0) ? i_digit_0 : 4'd0;
        e1 = (i_digit_count > 4'd1) ? i_digit_1 : 4'd0;
        e2 = (i_digit_count > 4'd2) ? i_digit_2 : 4'd0;
        e3 = (i_digit_count > 4'd3) ? i_digit_3 : 4'd0;
        e4 = (i_digit_count > 4'd4) ? i_digit_4 : 4'd0;
        e5 = (i_digit_count > 4'd5) ? i_digit_5 : 4'd0;
    end

    // Range checks on the digits that take part.
    always_comb begin
        over9 = (e0 > 4'd9) || (e1 > 4'd9) || (e2 > 4'd9) ||
                (e3 > 4'd9) || (e4 > 4'd9) || (e5 > 4'd9);
        bad   = (i_digit_count == 4'd0) || over9 || (e0 > 4'd1) ||
                ((e0 == 4'd1) && (e1 > 4'd2)) || (e2 > 4'd5) || (e4 > 4'd5);
    end

    // Weighted sum of the digits, and the same time as display digits.
    always_comb begin
        o_entry.ok       = !bad;
        o_entry.seconds  = alc_pkg::SEC_W'(17'(e0) * 17'd36000 + 17'(e1) * 17'd3600 +
                                           17'(e2) * 17'd600 + 17'(e3) * 17'd60 +
                                           17'(e4) * 17'd10 + 17'(e5));
        o_entry.sec_ones = e5;
        o_entry.sec_tens = e4[2:0];
        o_entry.min_ones = e3;
        o_entry.min_tens = e2[2:0];
        o_entry.hours    = 5'(5'(e0) * 5'd10 + 5'(e1));
    end

endmodule

// ===== hdl/alc_core.sv =====
// Mode sequencer with clock, alarm and display state.
module alc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_commit,
    input  logic [2:0]       i_operation,
    input  logic [3:0]       i_digit_count,
    input  alc_pkg::t_entry  i_entry,
    output alc_pkg::t_result o_result
);

    logic [2:0]               r_mode, n_mode;
    logic [alc_pkg::SEC_W-1:0] r_clk_sec, n_clk_sec;
    logic [alc_pkg::SEC_W-1:0] r_alm_sec, n_alm_sec;
    logic                     r_ring, n_ring;
    // Clock time as digits.
    logic [3:0] r_cs1, n_cs1;
    logic [2:0] r_cs10, n_cs10;
    logic [3:0] r_cm1, n_cm1;
    logic [2:0] r_cm10, n_cm10;
    logic [4:0] r_ch, n_ch;
    // Displayed time as digits.
    logic [3:0] r_ds1, n_ds1;
    logic [2:0] r_ds10, n_ds10;
    logic [3:0] r_dm1, n_dm1;
    logic [2:0] r_dm10, n_dm10;
    logic [4:0] r_dh, n_dh;

    logic [1:0]                msg;
    logic [alc_pkg::SEC_W:0]   tick_sum;
    logic                      wrap;
    logic [alc_pkg::SEC_W-1:0] tick_sec;
    logic [3:0] t_s1;
    logic [2:0] t_s10;
    logic [3:0] t_m1;
    logic [2:0] t_m10;
    logic [4:0] t_h;
    logic       entry_act;

    // Clock after one tick, in binary and as digits with carries.
    always_comb begin
        tick_sum = {1'b0, r_clk_sec} + (alc_pkg::SEC_W + 1)'(1);
        wrap     = tick_sum >= (alc_pkg::SEC_W + 1)'(alc_pkg::DAY_SECONDS);
        tick_sec = wrap ? '0 : tick_sum[alc_pkg::SEC_W-1:0];
        t_s1  = r_cs1;
        t_s10 = r_cs10;
        t_m1  = r_cm1;
        t_m10 = r_cm10;
        t_h   = r_ch;
        if (wrap) begin
            t_s1  = '0;
            t_s10 = '0;
            t_m1  = '0;
            t_m10 = '0;
            t_h   = '0;
        end else if (r_cs1 != 4'd9) begin
            t_s1 = r_cs1 + 4'd1;
        end else begin
            t_s1 = '0;
            if (r_cs10 != 3'd5) begin
                t_s10 = r_cs10 + 3'd1;
            end else begin
                t_s10 = '0;
                if (r_cm1 != 4'd9) begin
                    t_m1 = r_cm1 + 4'd1;
                end else begin
                    t_m1 = '0;
                    if (r_cm10 != 3'd5) begin
                        t_m10 = r_cm10 + 3'd1;
                    end else begin
                        t_m10 = '0;
                        t_h   = r_ch + 5'd1;
                    end
                end
            end
        end
    end

    // Mode transitions and state updates for one event.
    always_comb begin
        n_mode    = r_mode;
        n_clk_sec = r_clk_sec;
        n_alm_sec = r_alm_sec;
        n_ring    = r_ring;
        n_cs1     = r_cs1;
        n_cs10    = r_cs10;
        n_cm1     = r_cm1;
        n_cm10    = r_cm10;
        n_ch      = r_ch;
        n_ds1     = r_ds1;
        n_ds10    = r_ds10;
        n_dm1     = r_dm1;
        n_dm10    = r_dm10;
        n_dh      = r_dh;
        msg       = alc_pkg::MSG_NONE;
        entry_act = (i_operation == alc_pkg::OP_DIGITS) && (i_digit_count != 4'd0);
        unique case (r_mode) inside
            alc_pkg::MODE_CLOCK, alc_pkg::MODE_ALARM: begin
                if (entry_act) begin
                    if (!i_entry.ok) begin
                        msg = alc_pkg::MSG_BAD;
                    end else begin
                        if (r_mode == alc_pkg::MODE_CLOCK) begin
                            n_clk_sec = i_entry.seconds;
                            n_cs1     = i_entry.sec_ones;
                            n_cs10    = i_entry.sec_tens;
                            n_cm1     = i_entry.min_ones;
                            n_cm10    = i_entry.min_tens;
                            n_ch      = i_entry.hours;
                        end else begin
                            n_alm_sec = i_entry.seconds;
                        end
                        n_mode = alc_pkg::MODE_RUN;
                    end
                end
            end
            alc_pkg::MODE_RUN: begin
                if (i_operation == alc_pkg::OP_SETCLK) begin
                    n_mode = alc_pkg::MODE_CLOCK;
                    msg    = alc_pkg::MSG_CLOCK;
                end else if (i_operation == alc_pkg::OP_SETALM) begin
                    n_mode = alc_pkg::MODE_ALARM;
                    msg    = alc_pkg::MSG_ALARM;
                end else if (i_operation == alc_pkg::OP_TICK) begin
                    n_clk_sec = tick_sec;
                    n_cs1     = t_s1;
                    n_cs10    = t_s10;
                    n_cm1     = t_m1;
                    n_cm10    = t_m10;
                    n_ch      = t_h;
                    n_ds1     = t_s1;
                    n_ds10    = t_s10;
                    n_dm1     = t_m1;
                    n_dm10    = t_m10;
                    n_dh      = t_h;
                    if (tick_sec == r_alm_sec) begin
                        n_mode = alc_pkg::MODE_RING;
                    end
                end
            end
            alc_pkg::MODE_RING: begin
                if (i_operation == alc_pkg::OP_CANCEL) begin
                    n_mode = alc_pkg::MODE_IDLE;
                    n_ring = 1'b0;
                end else begin
                    n_ring = !r_ring;
                end
            end
            default: begin
                // Idle, and any code that cannot arise.
                n_mode = alc_pkg::MODE_IDLE;
                if (i_operation == alc_pkg::OP_SETCLK) begin
                    n_mode = alc_pkg::MODE_CLOCK;
                    msg    = alc_pkg::MSG_CLOCK;
                end else if (i_operation == alc_pkg::OP_SETALM) begin
                    n_mode = alc_pkg::MODE_ALARM;
                    msg    = alc_pkg::MSG_ALARM;
                end
            end
        endcase
    end

    // Result word seen after this event's update.
    always_comb begin
        o_result.mode_now   = n_mode;
        o_result.message    = msg;
        o_result.sec_ones   = n_ds1;
        o_result.sec_tens   = n_ds10;
        o_result.min_ones   = n_dm1;
        o_result.min_tens   = n_dm10;
        o_result.hour_leds  = n_dh[3:0];
        o_result.alarm_leds = {8{n_ring}};
    end

    // State registers, updated once for each committed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= alc_pkg::MODE_IDLE;
            r_clk_sec <= '0;
            r_alm_sec <= '0;
            r_ring    <= 1'b0;
            r_cs1     <= '0;
            r_cs10    <= '0;
            r_cm1     <= '0;
            r_cm10    <= '0;
            r_ch      <= '0;
            r_ds1     <= '0;
            r_ds10    <= '0;
            r_dm1     <= '0;
            r_dm10    <= '0;
            r_dh      <= '0;
        end else if (i_commit) begin
            r_mode    <= n_mode;
            r_clk_sec <= n_clk_sec;
            r_alm_sec <= n_alm_sec;
            r_ring    <= n_ring;
            r_cs1     <= n_cs1;
            r_cs10    <= n_cs10;
            r_cm1     <= n_cm1;
            r_cm10    <= n_cm10;
            r_ch      <= n_ch;
            r_ds1     <= n_ds1;
            r_ds10    <= n_ds10;
            r_dm1     <= n_dm1;
            r_dm10    <= n_dm10;
            r_dh      <= n_dh;
        end
    end

endmodule
